FILE: sv/reb_pkg.sv
// Shared types, constants and codes for the range encoder with byte output.
package reb_pkg;

    // Coder constants
    localparam int unsigned PENDING_MAX   = 32;
    localparam int unsigned PEND_W        = 6;
    localparam int unsigned ENC_SHIFTS    = 4;
    localparam int unsigned FLUSH_SHIFTS  = 5;
    localparam int unsigned TOTAL_MAX     = 16;
    localparam logic [31:0] RANGE_RESET   = 32'hFFFF_FFFF;
    localparam logic [31:0] TOP_LIMIT     = 32'h0100_0000;
    localparam logic [32:0] FF_WINDOW     = 33'h0_FF00_0000;
    localparam logic [7:0]  FILL_BYTE     = 8'hFF;

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INTERVAL = 2'd1;
    localparam logic [1:0] ERR_PENDING  = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [15:0] cum_start;
        logic [16:0] sym_count;
        logic [4:0]  total_bits;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] error;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic shift;
        logic emit;
        logic finish;
        logic clear_state;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_invalid;
        logic range_small;
        logic shift_emits;
        logic pending_zero;
        logic can_put;
        logic can_finish;
    } status_t;

endpackage

FILE: sv/range_encoder_byte_out.sv
// Sequence: encode takes an accept, the MUL1 and MUL2 multiplies, up to ENC_SHIFTS byte shifts,
// one emit per byte and a finish; a rejected interval takes an accept and a finish. Flush takes
// an accept, FLUSH_SHIFTS byte shifts, one emit per emitted byte and a finish.
// Throughput: one request at a time; the sequencer steps one multiply, shift or byte per cycle,
// and a stalled result holds it.
// Reset (rst_n, async low): coder returns to low 0, range all ones, no pending bytes.
module range_encoder_byte_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  reb_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output reb_pkg::rsp_t rsp_data
);
    import reb_pkg::*;

    cmd_t    cmd;
    status_t status;

    reb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_operation (req_data.operation),
        .status        (status),
        .req_stall     (req_stall),
        .cmd           (cmd)
    );

    reb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    // Checks on the sequencer and result stream
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.shift, cmd.emit, cmd.finish}))
        else $error("more than one datapath command at once");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.finish) |-> status.can_finish || (cmd.emit && status.can_put))
        else $error("result pushed while output register is blocked");

    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.last) |-> (rsp_data.byte_valid && rsp_data.error == ERR_NONE))
        else $error("non-final result without a byte or with an error");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.error == ERR_NONE || rsp_data.error == ERR_INTERVAL
                       || rsp_data.error == ERR_PENDING))
        else $error("unknown error code on result");

endmodule

FILE: sv/reb_dp.sv
// Datapath: coder state, multipliers, byte shifter, held byte and result register.
module reb_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  reb_pkg::req_t    req_data,
    input  logic             rsp_stall,
    input  reb_pkg::cmd_t    cmd,
    output reb_pkg::status_t status,
    output logic             rsp_valid,
    output reb_pkg::rsp_t    rsp_data
);
    import reb_pkg::*;

    logic [32:0]       low_reg, low_next;
    logic [31:0]       range_reg, range_next;
    logic [7:0]        cached_reg, cached_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [1:0]        err_reg, err_next;

    logic [15:0] cum_reg;
    logic [16:0] cnt_reg;
    logic [4:0]  bits_reg;
    logic [31:0] step_reg;
    logic [47:0] prod_reg;

    logic [7:0] emit_byte_reg, emit_byte_next;
    logic [7:0] fill_reg, fill_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;

    logic       out_valid_reg, out_valid_next;
    rsp_t       out_reg, out_next;

    logic [17:0] iv_sum;
    logic [17:0] iv_limit;
    logic [31:0] step_calc;
    logic [48:0] range_prod;
    logic        out_free;

    // Interval check on the incoming request
    assign iv_sum   = 18'(req_data.cum_start) + 18'(req_data.sym_count);
    assign iv_limit = 18'(1) << req_data.total_bits;
    assign status.req_invalid = (req_data.sym_count == 17'd0)
                             || (req_data.total_bits > 5'(TOTAL_MAX))
                             || (iv_sum > iv_limit);

    assign out_free            = !out_valid_reg || !rsp_stall;
    assign status.range_small  = range_reg < TOP_LIMIT;
    assign status.shift_emits  = (low_reg < FF_WINDOW) || low_reg[32];
    assign status.pending_zero = (pending_reg == '0);
    assign status.can_put      = !held_valid_reg || out_free;
    assign status.can_finish   = out_free;

    assign step_calc  = range_reg >> bits_reg;
    assign range_prod = step_reg * cnt_reg;

    // Field and multiplier registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cum_reg  <= req_data.cum_start;
            cnt_reg  <= req_data.sym_count;
            bits_reg <= req_data.total_bits;
        end
        if (cmd.mul1)
        begin
            step_reg <= step_calc;
            prod_reg <= cum_reg * step_calc;
        end
    end

    // Coder state update
    always_comb
    begin
        low_next        = low_reg;
        range_next      = range_reg;
        cached_next     = cached_reg;
        pending_next    = pending_reg;
        err_next        = err_reg;
        emit_byte_next  = emit_byte_reg;
        fill_next       = fill_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_next        = out_reg;

        if (cmd.load)
        begin
            err_next = (req_data.operation == OP_ENCODE && status.req_invalid)
                       ? ERR_INTERVAL : ERR_NONE;
        end

        if (cmd.mul2)
        begin
            low_next   = low_reg + prod_reg[32:0];
            range_next = range_prod[31:0];
        end

        // One byte shift of the low value
        if (cmd.shift)
        begin
            range_next = {range_reg[23:0], 8'h00};
            if (status.shift_emits)
            begin
                emit_byte_next = cached_reg + 8'(low_reg[32]);
                fill_next      = low_reg[32] ? 8'h00 : FILL_BYTE;
                cached_next    = low_reg[31:24];
            end
            else if (pending_reg >= PEND_W'(PENDING_MAX))
            begin
                err_next = ERR_PENDING;
            end
            else
            begin
                pending_next = pending_reg + 1'b1;
            end
            low_next = {1'b0, low_reg[23:0], 8'h00};
        end

        // Emit one byte into the held stage, pushing the older one out
        if (cmd.emit)
        begin
            held_byte_next  = emit_byte_reg;
            held_valid_next = 1'b1;
            if (held_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = '{out_byte: held_byte_reg, byte_valid: 1'b1,
                                   last: 1'b0, error: ERR_NONE};
            end
            if (!status.pending_zero)
            begin
                emit_byte_next = fill_reg;
                pending_next   = pending_reg - 1'b1;
            end
        end

        // Final result of the request
        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_next        = '{out_byte: held_valid_reg ? held_byte_reg : 8'h00,
                                byte_valid: held_valid_reg, last: 1'b1, error: err_reg};
            held_valid_next = 1'b0;
        end

        if (cmd.clear_state)
        begin
            low_next     = '0;
            range_next   = RANGE_RESET;
            cached_next  = '0;
            pending_next = '0;
        end
    end

    // Control and coder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= '0;
            range_reg      <= RANGE_RESET;
            cached_reg     <= '0;
            pending_reg    <= '0;
            err_reg        <= ERR_NONE;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            low_reg        <= low_next;
            range_reg      <= range_next;
            cached_reg     <= cached_next;
            pending_reg    <= pending_next;
            err_reg        <= err_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        emit_byte_reg <= emit_byte_next;
        fill_reg      <= fill_next;
        held_byte_reg <= held_byte_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

FILE: sv/reb_ctrl.sv
// Controller: sequences multiply, byte shift, emission and completion per request.
module reb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_operation,
    input  reb_pkg::status_t status,
    output logic             req_stall,
    output reb_pkg::cmd_t    cmd
);
    import reb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL1   = 3'd1;
    localparam logic [2:0] ST_MUL2   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] iter_reg, iter_next;
    logic       flush_reg, flush_next;
    logic [2:0] iter_limit;

    assign req_stall  = (state_reg != ST_IDLE);
    assign iter_limit = flush_reg ? 3'(FLUSH_SHIFTS) : 3'(ENC_SHIFTS);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        flush_next = flush_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    flush_next = (req_operation == OP_FLUSH);
                    if (req_operation == OP_FLUSH)
                        state_next = ST_SHIFT;
                    else if (status.req_invalid)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (iter_reg < iter_limit && (flush_reg || status.range_small))
                begin
                    cmd.shift  = 1'b1;
                    iter_next  = iter_reg + 1'b1;
                    state_next = status.shift_emits ? ST_EMIT : ST_SHIFT;
                end
                else
                begin
                    cmd.clear_state = flush_reg;
                    state_next      = ST_FINISH;
                end
            end
            ST_EMIT:
            begin
                if (status.can_put)
                begin
                    cmd.emit = 1'b1;
                    if (status.pending_zero)
                        state_next = ST_SHIFT;
                end
            end
            ST_FINISH:
            begin
                if (status.can_finish)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            flush_reg <= flush_next;
        end
    end

endmodule
